// ----- sv/jse_pkg.sv -----
// ---------------------------------------------------------------------------
// jse_pkg: shared types and helpers for the json string escaper
// item descriptor passed from front to back, character constants, lookups
// ---------------------------------------------------------------------------
package jse_pkg;

    localparam int QueueDepth = 4;

    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_U       = 8'h75;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CTRL_LIMIT = 8'h20;

    // how the back end expands an item
    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_SHORT = 2'd1,
        KIND_UNI   = 2'd2,
        KIND_CLOSE = 2'd3
    } kind_t;

    typedef struct packed {
        logic       open_quote; // emit an opening quote first
        kind_t      kind;
        logic [7:0] char_val;   // raw byte, or escape letter for short escapes
    } desc_t;

    // short escape letter, zero when the byte has none
    function automatic logic [7:0] short_escape(input logic [7:0] c);
        logic [7:0] r;
        case (c)
            8'h22:   r = 8'h22;
            8'h5C:   r = 8'h5C;
            8'h08:   r = 8'h62;
            8'h0C:   r = 8'h66;
            8'h0A:   r = 8'h6E;
            8'h0D:   r = 8'h72;
            8'h09:   r = 8'h74;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        logic [7:0] r;
        if (n < 4'd10) begin
            r = CH_ZERO + {4'd0, n};
        end else begin
            r = CH_A + {4'd0, n} - 8'd10;
        end
        return r;
    endfunction

    // escaped length without the opening quote
    function automatic logic [2:0] body_len(input kind_t k);
        logic [2:0] r;
        case (k)
            KIND_PLAIN: r = 3'd1;
            KIND_SHORT: r = 3'd2;
            KIND_UNI:   r = 3'd6;
            KIND_CLOSE: r = 3'd1;
            default:    r = 3'd1;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/jse_front.sv -----
// ---------------------------------------------------------------------------
// jse_front: item intake and classification
// tracks whether a string is open and turns each item into a descriptor
// ---------------------------------------------------------------------------
module jse_front
    import jse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic [7:0] s_tdata,
    input  logic       s_tuser,
    input  logic       q_ready,
    output logic       push,
    output desc_t      push_desc,
    output logic       string_open
);

    logic       string_open_reg;
    logic       string_open_next;
    logic [7:0] esc;

    assign push = s_tvalid && q_ready;

    always_comb begin
        esc                  = short_escape(s_tdata);
        push_desc.open_quote = !string_open_reg;
        push_desc.char_val   = s_tdata;
        if (s_tuser) begin
            push_desc.kind = KIND_CLOSE;
        end else if (esc != 8'h00) begin
            push_desc.kind     = KIND_SHORT;
            push_desc.char_val = esc;
        end else if (s_tdata < CTRL_LIMIT) begin
            push_desc.kind = KIND_UNI;
        end else begin
            push_desc.kind = KIND_PLAIN;
        end
    end

    always_comb begin
        string_open_next = string_open_reg;
        if (push) begin
            string_open_next = !s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            string_open_reg <= 1'b0;
        end else begin
            string_open_reg <= string_open_next;
        end
    end

    assign string_open = string_open_reg;

endmodule

// ----- sv/jse_queue.sv -----
// ---------------------------------------------------------------------------
// jse_queue: descriptor queue
// small fifo that decouples classification from expansion
// ---------------------------------------------------------------------------
module jse_queue
    import jse_pkg::*;
#(
    parameter int DEPTH = QueueDepth
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  desc_t push_desc,
    output logic  ready,
    input  logic  pop,
    output logic  head_valid,
    output desc_t head_desc
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    desc_t            entries_reg [DEPTH];
    logic [PtrW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;
    logic             do_pop;

    assign ready      = (count_reg != CntW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_desc  = entries_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

// ----- sv/jse_back.sv -----
// ---------------------------------------------------------------------------
// jse_back: escape sequencer
// walks the bytes of one descriptor into the output register
// ---------------------------------------------------------------------------
module jse_back
    import jse_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       head_valid,
    input  desc_t      head_desc,
    output logic       pop,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast
);

    logic [2:0] step_reg, step_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg;
    logic       m_tlast_reg;
    logic       load;
    logic [2:0] total;
    logic [2:0] body_idx;
    logic       is_last;
    logic [7:0] cur_byte;
    logic [7:0] body_byte;

    assign load     = (!m_tvalid_reg || m_tready) && head_valid;
    assign total    = body_len(head_desc.kind) + {2'b00, head_desc.open_quote};
    assign is_last  = (step_reg == total - 3'd1);
    assign body_idx = step_reg - {2'b00, head_desc.open_quote};
    assign pop      = load && is_last;

    always_comb begin
        case (head_desc.kind)
            KIND_PLAIN: body_byte = head_desc.char_val;
            KIND_SHORT: body_byte = (body_idx == 3'd0) ? CH_BSLASH : head_desc.char_val;
            KIND_UNI: begin
                case (body_idx)
                    3'd0:    body_byte = CH_BSLASH;
                    3'd1:    body_byte = CH_U;
                    3'd2:    body_byte = CH_ZERO;
                    3'd3:    body_byte = CH_ZERO;
                    3'd4:    body_byte = hex_digit(head_desc.char_val[7:4]);
                    default: body_byte = hex_digit(head_desc.char_val[3:0]);
                endcase
            end
            KIND_CLOSE: body_byte = CH_QUOTE;
            default:    body_byte = CH_QUOTE;
        endcase
        // opening quote comes before the body
        cur_byte = (head_desc.open_quote && step_reg == 3'd0) ? CH_QUOTE : body_byte;
    end

    always_comb begin
        step_next     = step_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if (load) begin
            m_tvalid_next = 1'b1;
            step_next     = is_last ? 3'd0 : step_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg     <= 3'd0;
            m_tvalid_reg <= 1'b0;
        end else begin
            step_reg     <= step_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= cur_byte;
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- sv/json_string_escaper.sv -----
// an item taken at the input is written into the descriptor queue, then loaded into the output
//   register, from which its first result byte can be taken
// throughput: one input item per cycle while results are single bytes and m_tready is high;
//   an item that expands to n bytes (1 to 7) holds the output sequencer until all n are loaded
// the descriptor queue (QUEUE_DEPTH entries) absorbs long escapes so intake keeps going until it is full
// reset: aresetn synchronous, active low; clears string state, queue and output valid
// ---------------------------------------------------------------------------
// json_string_escaper: streaming json string literal encoder
// front classifies bytes, queue decouples, back emits escaped bytes
// ---------------------------------------------------------------------------
module json_string_escaper
    import jse_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic       aclk,
    input  logic       aresetn,
    // input item channel
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] cmd: 0 data byte, 1 end of string
    // result item channel
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast
);

    logic  push;
    desc_t push_desc;
    logic  q_ready;
    logic  pop;
    logic  head_valid;
    desc_t head_desc;
    logic  string_open;

    // intake is held only by a full queue
    assign s_tready = q_ready;

    jse_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_ready     (q_ready),
        .push        (push),
        .push_desc   (push_desc),
        .string_open (string_open)
    );

    jse_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_desc  (push_desc),
        .ready      (q_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    jse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_desc  (head_desc),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // end of string closes the string, a data byte opens it
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (string_open == !$past(s_tuser)))
        else $error("string state not updated by accepted item");

    // with nothing queued the output register cannot gain a new item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!head_valid && (!m_tvalid || m_tready)) |=> !m_tvalid)
        else $error("result produced with empty queue");

    // the back end only retires a descriptor it actually holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule
